/* sv/mfch_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/filter-id hash package
// Shared widths, constants, pipeline beat type and the CRC step function.
// ----------------------------------------------------------------------------
package mfch_pkg;

  localparam int unsigned TableEntries  = 2048;
  localparam int unsigned FidW          = 8;
  localparam int unsigned MacW          = 48;
  localparam int unsigned BucketW       = 11;
  localparam int unsigned HashW         = 16;
  localparam int unsigned RemW          = 20;
  localparam int unsigned GuardW        = RemW - HashW;
  localparam int unsigned NumFolds      = 4;
  localparam int unsigned StepsPerFold  = 20;
  localparam int unsigned StagesPerFold = 4;
  localparam int unsigned StepsPerStage = StepsPerFold / StagesPerFold;
  localparam int unsigned NumStages     = NumFolds * StagesPerFold;

  localparam logic [HashW-1:0] HashInit  = 16'hFFFF;
  localparam logic [HashW-1:0] PolyReset = 16'h1021;
  localparam logic [HashW-1:0] IndexMask = HashW'(TableEntries - 1);

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MacW-1:0] mac;
  } mfch_beat_t;

  function automatic logic [RemW-1:0] crc_steps(input logic [RemW-1:0] rem_in,
                                                input logic [HashW-1:0] poly);
    logic [RemW-1:0] divisor;
    logic [RemW-1:0] rem;
    divisor = {1'b1, poly, {(GuardW - 1){1'b0}}};
    rem     = rem_in;
    for (int i = 0; i < StepsPerStage; i++) begin
      if (rem[RemW-1]) begin
        rem = rem ^ divisor;
      end
      rem = {rem[RemW-2:0], 1'b0};
    end
    return rem;
  endfunction

endpackage

/* sv/mfch_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/filter-id hash channels
// Request channel (filter id, MAC) and response channel (bucket index).
// ----------------------------------------------------------------------------
interface mfch_req_if;
  logic                      valid;
  logic                      ready;
  logic [mfch_pkg::FidW-1:0] filter_id;
  logic [mfch_pkg::MacW-1:0] mac_address;

  modport source (output valid, output filter_id, output mac_address, input ready);
  modport sink   (input valid, input filter_id, input mac_address, output ready);
endinterface

interface mfch_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mfch_pkg::BucketW-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

/* sv/mfch_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/filter-id hash pipeline stage
// Runs five CRC division steps on the remainder and registers the beat.
// ----------------------------------------------------------------------------
module mfch_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mfch_pkg::HashW-1:0]  poly_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mfch_pkg::mfch_beat_t        in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mfch_pkg::mfch_beat_t        out_data_o
);
  import mfch_pkg::*;

  logic       valid_q;
  mfch_beat_t data_q;
  mfch_beat_t data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.rem = crc_steps(in_data_i.rem, poly_i);
    data_d.mac = in_data_i.mac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* sv/mac_fid_crc16_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/filter-id CRC-16 hash
// Folds filter id and MAC into a CRC-16 with a programmable polynomial and
// gives the masked bucket index.
// ----------------------------------------------------------------------------
// Pipeline: four registered stages per fold.
// Throughput: one beat per cycle; each stage holds on its own when the
// response side stalls, so bubbles close up.
// Reset: pipeline valid bits clear, polynomial returns to 0x1021.
// ----------------------------------------------------------------------------
module mac_fid_crc16_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mfch_pkg::HashW-1:0] cfg_wdata_i,
  mfch_req_if.sink                   req_i,
  mfch_rsp_if.source                 rsp_o
);
  import mfch_pkg::*;

  logic [HashW-1:0] poly_q;

  logic       stg_valid [NumStages+1];
  logic       stg_ready [NumStages+1];
  mfch_beat_t stg_data  [NumStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  assign stg_valid[0]    = req_i.valid;
  assign req_i.ready     = stg_ready[0];
  assign stg_data[0].rem = '0;
  assign stg_data[0].mac = req_i.mac_address;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    mfch_beat_t pre;

    if (s % StagesPerFold == 0) begin : g_load
      localparam int unsigned Fold = s / StagesPerFold;
      logic [HashW-1:0] hash;
      logic [HashW-1:0] word;

      if (s == 0) begin : g_first
        assign hash = HashInit;
        assign word = {{(HashW - FidW){1'b0}}, req_i.filter_id};
      end else begin : g_next
        assign hash = stg_data[s].rem[RemW-1:GuardW];
        assign word = stg_data[s].mac[HashW*(NumFolds-1-Fold) +: HashW];
      end

      assign pre.rem = {{GuardW{1'b0}}, hash ^ word};
      assign pre.mac = stg_data[s].mac;
    end else begin : g_pass
      assign pre = stg_data[s];
    end

    mfch_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .poly_i      (poly_q),
      .in_valid_i  (stg_valid[s]),
      .in_ready_o  (stg_ready[s]),
      .in_data_i   (pre),
      .out_valid_o (stg_valid[s+1]),
      .out_ready_i (stg_ready[s+1]),
      .out_data_o  (stg_data[s+1])
    );
  end

  assign rsp_o.valid          = stg_valid[NumStages];
  assign stg_ready[NumStages] = rsp_o.ready;
  assign rsp_o.bucket_index   =
    BucketW'(stg_data[NumStages].rem[RemW-1:GuardW] & IndexMask);

endmodule

/* sv/mfch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/filter-id hash port checker
// Watches the top-level ports for stall and backpressure behavior and for bucket indices outside the table.
// ----------------------------------------------------------------------------
module mfch_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [mfch_pkg::BucketW-1:0] bucket_index_i
);
  import mfch_pkg::*;

  localparam logic [BucketW-1:0] OutMask = BucketW'(IndexMask);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(bucket_index_i))
    else $error("response payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request backpressure without a stalled response");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (bucket_index_i & ~OutMask) == '0)
    else $error("bucket index outside table");

endmodule

bind mac_fid_crc16_hash mfch_checker u_mfch_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .bucket_index_i (rsp_o.bucket_index)
);
